>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/mexp_pkg.sv
package mexp_pkg;

  localparam int DATA_W        = 32;
  localparam int WIDTH_DEFAULT = 32;

  typedef enum logic [0:0] {
    REG_MODULUS,
    REG_EXPONENT
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_MUL,
    S_SQR,
    S_DONE
  } mexp_state_t;

  typedef struct packed {
    logic start;
  } mm_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

endpackage

>>> rtl/mexp_if.sv
interface mexp_msg_if import mexp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] message;

  modport source (output valid, output message, input ready);
  modport sink   (input valid, input message, output ready);
endinterface

interface mexp_res_if import mexp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] cipher;

  modport source (output valid, output cipher, input ready);
  modport sink   (input valid, input cipher, output ready);
endinterface

interface mexp_cfg_if import mexp_pkg::*; ();
  logic              valid;
  logic              ready;
  cfg_reg_t          index;
  logic [DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/mexp_mulmod.sv
`include "assert_macros.svh"

module mexp_mulmod import mexp_pkg::*; #(
  parameter int WIDTH = WIDTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  mm_ctl_t          ctl,
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  input  logic [WIDTH:0]   m,
  output mm_stat_t         stat,
  output logic [WIDTH-1:0] product
);

  localparam int CNT_W = $clog2(WIDTH);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(WIDTH - 1);

  logic [WIDTH-1:0] a_q;
  logic [WIDTH-1:0] bsh;
  logic [WIDTH-1:0] r;
  logic [CNT_W-1:0] cnt;
  logic             active;
  logic             done;

  logic [WIDTH+1:0] t;
  logic [WIDTH+2:0] s1;
  logic [WIDTH+2:0] s2;
  logic [WIDTH-1:0] r_next;

  // one MSB-first step: r = (2r + b_i*a) mod m, with t below 3m
  always_comb begin
    t  = {1'b0, r, 1'b0} + {2'b00, (bsh[WIDTH-1] ? a_q : '0)};
    s1 = {1'b0, t} - {2'b00, m};
    s2 = {1'b0, t} - {1'b0, m, 1'b0};
    priority if (!s2[WIDTH+2]) begin
      r_next = s2[WIDTH-1:0];
    end else if (!s1[WIDTH+2]) begin
      r_next = s1[WIDTH-1:0];
    end else begin
      r_next = t[WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= active && (cnt == '0);
      if (ctl.start) begin
        active <= 1'b1;
      end else if (active && (cnt == '0)) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a_q <= a;
      bsh <= b;
      r   <= '0;
      cnt <= LAST;
    end else if (active) begin
      r   <= r_next;
      bsh <= bsh << 1;
      cnt <= cnt - 1'b1;
    end
  end

  assign stat.busy = active;
  assign stat.done = done;
  assign product   = r;

  `ASSERT_CLK(a_start_idle, ctl.start |-> !active, "mulmod started while busy")
  `ASSERT_CLK(a_done_after, done |-> $past(active), "mulmod done without a run")
  `ASSERT_CLK(a_run_ends, (active && !ctl.start) |=> (active || done), "mulmod run lost")

endmodule

>>> rtl/modular_exponentiation.sv
// Channel  Modport  Payload            Beat
// msg      sink     message[31:0]      valid && ready
// res      source   cipher[31:0]       valid && ready
// cfg      sink     index, data[31:0]  valid && ready (ready tied high)
//
// One shared mod-multiplier, one multiplier bit per cycle.
// Products per beat: one reduction, WIDTH squarings and popcount(exponent) multiplies.
// Synchronous reset: modulus 1, exponent 0, channels empty.
// msg ready only while idle; a result waiting in the output register does not block
// the next message until that one finishes too.
`include "assert_macros.svh"

module modular_exponentiation import mexp_pkg::*; #(
  parameter int WIDTH = WIDTH_DEFAULT
) (
  input logic clk,
  input logic rst,
  mexp_msg_if.sink   msg,
  mexp_res_if.source res,
  mexp_cfg_if.sink   cfg
);

  localparam int BIT_W = $clog2(WIDTH);
  localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(WIDTH - 1);

  mexp_state_t      state;
  mexp_state_t      state_next;
  logic             go;
  logic             go_next;

  logic [WIDTH-1:0] modulus;
  logic [WIDTH-1:0] exponent;
  logic [WIDTH:0]   m_eff;

  logic [WIDTH-1:0] msg_q;
  logic [WIDTH-1:0] sq;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] e_sh;
  logic [BIT_W-1:0] bitcnt;

  logic             out_valid;
  logic [WIDTH-1:0] out_data;
  logic             load_out;

  mm_ctl_t          ctl;
  mm_stat_t         stat;
  logic [WIDTH-1:0] op_a;
  logic [WIDTH-1:0] op_b;
  logic [WIDTH-1:0] product;

  // zero modulus stands for 2^WIDTH
  assign m_eff = (modulus == '0) ? {1'b1, {WIDTH{1'b0}}} : {1'b0, modulus};

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus  <= WIDTH'(1);
      exponent <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_MODULUS:  modulus  <= cfg.data[WIDTH-1:0];
        REG_EXPONENT: exponent <= cfg.data[WIDTH-1:0];
      endcase
    end
  end

  mexp_mulmod #(.WIDTH(WIDTH)) u_mulmod (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .a       (op_a),
    .b       (op_b),
    .m       (m_eff),
    .stat    (stat),
    .product (product)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (msg.valid) state_next = S_REDUCE;
      end
      S_REDUCE: begin
        if (stat.done) state_next = exponent[0] ? S_MUL : S_SQR;
      end
      S_MUL: begin
        if (stat.done) state_next = S_SQR;
      end
      S_SQR: begin
        if (stat.done) begin
          if (bitcnt == LAST_BIT) begin
            state_next = S_DONE;
          end else begin
            state_next = e_sh[1] ? S_MUL : S_SQR;
          end
        end
      end
      S_DONE: begin
        if (!out_valid || res.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    msg.ready = (state == S_IDLE);
    ctl.start = go;
    load_out  = (state == S_DONE) && (!out_valid || res.ready);
    go_next   = ((state_next == S_REDUCE) || (state_next == S_MUL) ||
                 (state_next == S_SQR)) && ((state == S_IDLE) || stat.done);
    unique case (state)
      S_REDUCE: begin
        op_a = WIDTH'(1);
        op_b = msg_q;
      end
      S_MUL: begin
        op_a = sq;
        op_b = acc;
      end
      S_SQR: begin
        op_a = sq;
        op_b = sq;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      go        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      go    <= go_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (msg.valid && msg.ready) begin
      msg_q <= msg.message[WIDTH-1:0];
    end
    if (stat.done) begin
      unique case (state)
        S_REDUCE: begin
          sq     <= product;
          acc    <= WIDTH'(1);
          e_sh   <= exponent;
          bitcnt <= '0;
        end
        S_MUL: begin
          acc <= product;
        end
        S_SQR: begin
          sq     <= product;
          e_sh   <= e_sh >> 1;
          bitcnt <= bitcnt + 1'b1;
        end
        default: begin
        end
      endcase
    end
    if (load_out) begin
      out_data <= acc;
    end
  end

  assign res.valid  = out_valid;
  assign res.cipher = DATA_W'(out_data);

  `ASSERT_CLK(a_go_idle_unit, go |-> !stat.busy, "multiply issued while unit busy")
  `ASSERT_CLK(a_done_in_op, stat.done |-> ((state == S_REDUCE) || (state == S_MUL) ||
    (state == S_SQR)), "product finished outside an operation")
  `ASSERT_CLK(a_accept_starts, (msg.valid && msg.ready) |=> (go && (state == S_REDUCE)),
    "accepted beat did not start reduction")

endmodule
